// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int QUO_BITS   = DATA_WIDTH + 1;
   localparam int PRE_SHIFT  = QUO_BITS - FRAC_BITS;
   localparam int DIV_STEPS  = QUO_BITS;
   localparam int LATENCY    = 4 + DIV_STEPS + 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                    kind;
      logic signed [DATA_WIDTH-1:0]  a_re;
      logic signed [DATA_WIDTH-1:0]  a_im;
      logic signed [DATA_WIDTH-1:0]  b_re;
      logic signed [DATA_WIDTH-1:0]  b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  res_re;
      logic signed [DATA_WIDTH-1:0]  res_im;
      logic                          overflow;
      logic                          div_zero;
   } rsp_type;

   typedef struct packed {
      logic [PROD_W:0]     rem;
      logic [QUO_BITS-1:0] quo;
      logic [QUO_BITS-1:0] nbits;
   } div_lane_type;

   typedef struct packed {
      op_type              kind;
      logic                div_zero;
      logic [PROD_W-1:0]   den;
      logic                neg_re;
      logic                neg_im;
      logic                big_re;
      logic                big_im;
      logic [PROD_W-1:0]   mag_re;
      logic [PROD_W-1:0]   mag_im;
      div_lane_type        re;
      div_lane_type        im;
   } pipe_type;

endpackage

// ===== rtl/cau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Operand register, products, sums and sign/magnitude split with divider
// set-up, four register stages.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_req,
   output logic     out_valid,
   output pipe_type out_pipe
);

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   req_type                   req1_ff;
   op_type                    kind2_ff, kind3_ff;
   logic signed [PROD_W-1:0]  ac_ff, bd_ff, bc_ff, ad_ff, cc_ff, dd_ff;
   logic signed [PROD_W-1:0]  ac_in, bd_in, bc_in, ad_in, cc_in, dd_in;
   logic signed [DATA_WIDTH:0] sr_ff, si_ff, sr_in, si_in;
   logic signed [PROD_W:0]    xre_ff, xim_ff, xre_in, xim_in;
   logic [PROD_W-1:0]         den3_ff, den3_in;
   pipe_type                  pipe4_ff, pipe4_in;
   logic [PROD_W:0]           absre, absim;

   assign ac_in = PROD_W'(req1_ff.a_re) * PROD_W'(req1_ff.b_re);
   assign bd_in = PROD_W'(req1_ff.a_im) * PROD_W'(req1_ff.b_im);
   assign bc_in = PROD_W'(req1_ff.a_im) * PROD_W'(req1_ff.b_re);
   assign ad_in = PROD_W'(req1_ff.a_re) * PROD_W'(req1_ff.b_im);
   assign cc_in = PROD_W'(req1_ff.b_re) * PROD_W'(req1_ff.b_re);
   assign dd_in = PROD_W'(req1_ff.b_im) * PROD_W'(req1_ff.b_im);

   always_comb begin
      if (op_type'(req1_ff.kind) == OP_SUB) begin
         sr_in = $signed({req1_ff.a_re[DATA_WIDTH-1], req1_ff.a_re})
               - $signed({req1_ff.b_re[DATA_WIDTH-1], req1_ff.b_re});
         si_in = $signed({req1_ff.a_im[DATA_WIDTH-1], req1_ff.a_im})
               - $signed({req1_ff.b_im[DATA_WIDTH-1], req1_ff.b_im});
      end else begin
         sr_in = $signed({req1_ff.a_re[DATA_WIDTH-1], req1_ff.a_re})
               + $signed({req1_ff.b_re[DATA_WIDTH-1], req1_ff.b_re});
         si_in = $signed({req1_ff.a_im[DATA_WIDTH-1], req1_ff.a_im})
               + $signed({req1_ff.b_im[DATA_WIDTH-1], req1_ff.b_im});
      end
   end

   always_comb begin
      case (kind2_ff)
         OP_MUL: begin
            xre_in = $signed({ac_ff[PROD_W-1], ac_ff}) - $signed({bd_ff[PROD_W-1], bd_ff});
            xim_in = $signed({bc_ff[PROD_W-1], bc_ff}) + $signed({ad_ff[PROD_W-1], ad_ff});
         end
         OP_DIV: begin
            xre_in = $signed({ac_ff[PROD_W-1], ac_ff}) + $signed({bd_ff[PROD_W-1], bd_ff});
            xim_in = $signed({bc_ff[PROD_W-1], bc_ff}) - $signed({ad_ff[PROD_W-1], ad_ff});
         end
         default: begin
            xre_in = $signed({{(PROD_W-DATA_WIDTH){sr_ff[DATA_WIDTH]}}, sr_ff});
            xim_in = $signed({{(PROD_W-DATA_WIDTH){si_ff[DATA_WIDTH]}}, si_ff});
         end
      endcase
      den3_in = $unsigned(cc_ff) + $unsigned(dd_ff);
   end

   always_comb begin
      absre = xre_ff[PROD_W] ? $unsigned(-xre_ff) : $unsigned(xre_ff);
      absim = xim_ff[PROD_W] ? $unsigned(-xim_ff) : $unsigned(xim_ff);
      pipe4_in          = '0;
      pipe4_in.kind     = kind3_ff;
      pipe4_in.den      = den3_ff;
      pipe4_in.div_zero = (kind3_ff == OP_DIV) && (den3_ff == '0);
      pipe4_in.neg_re   = xre_ff[PROD_W];
      pipe4_in.neg_im   = xim_ff[PROD_W];
      if (kind3_ff == OP_MUL) begin
         pipe4_in.mag_re = absre[PROD_W-1:0] >> FRAC_BITS;
         pipe4_in.mag_im = absim[PROD_W-1:0] >> FRAC_BITS;
      end else begin
         pipe4_in.mag_re = absre[PROD_W-1:0];
         pipe4_in.mag_im = absim[PROD_W-1:0];
      end
      pipe4_in.big_re   = (absre[PROD_W-1:0] >> PRE_SHIFT) >= den3_ff;
      pipe4_in.big_im   = (absim[PROD_W-1:0] >> PRE_SHIFT) >= den3_ff;
      pipe4_in.re.rem   = {1'b0, absre[PROD_W-1:0] >> PRE_SHIFT};
      pipe4_in.im.rem   = {1'b0, absim[PROD_W-1:0] >> PRE_SHIFT};
      pipe4_in.re.nbits = QUO_BITS'(absre[PROD_W-1:0] << FRAC_BITS);
      pipe4_in.im.nbits = QUO_BITS'(absim[PROD_W-1:0] << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      req1_ff  <= in_req;
      kind2_ff <= op_type'(req1_ff.kind);
      ac_ff    <= ac_in;
      bd_ff    <= bd_in;
      bc_ff    <= bc_in;
      ad_ff    <= ad_in;
      cc_ff    <= cc_in;
      dd_ff    <= dd_in;
      sr_ff    <= sr_in;
      si_ff    <= si_in;
      kind3_ff <= kind2_ff;
      xre_ff   <= xre_in;
      xim_ff   <= xim_in;
      den3_ff  <= den3_in;
      pipe4_ff <= pipe4_in;
   end

   assign out_valid = v4_ff;
   assign out_pipe  = pipe4_ff;

endmodule

// ===== rtl/cau_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring-division step, applied to both lanes.
// ----------------------------------------------------------------------------
module cau_div_step import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  pipe_type in_pipe,
   output logic     out_valid,
   output pipe_type out_pipe
);

   logic     valid_ff;
   pipe_type pipe_ff, pipe_in;

   function automatic div_lane_type step(input div_lane_type l, input logic [PROD_W-1:0] den);
      logic [PROD_W:0] t;
      logic            ge;
      div_lane_type    r;
      t       = {l.rem[PROD_W-1:0], l.nbits[QUO_BITS-1]};
      ge      = t >= {1'b0, den};
      r.rem   = ge ? (t - {1'b0, den}) : t;
      r.quo   = {l.quo[QUO_BITS-2:0], ge};
      r.nbits = {l.nbits[QUO_BITS-2:0], 1'b0};
      return r;
   endfunction

   always_comb begin
      pipe_in    = in_pipe;
      pipe_in.re = step(in_pipe.re, in_pipe.den);
      pipe_in.im = step(in_pipe.im, in_pipe.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pipe_ff <= pipe_in;
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

// ===== rtl/cau_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_out
// Result selection, saturation and flag generation into the output register.
// ----------------------------------------------------------------------------
module cau_out import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  pipe_type in_pipe,
   output logic     out_valid,
   output rsp_type  out_rsp
);

   localparam logic [PROD_W-1:0] MAX_POS = PROD_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic [PROD_W-1:0] MAX_NEG = PROD_W'(64'd1 << (DATA_WIDTH - 1));

   logic              valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [PROD_W-1:0] fin_re, fin_im;
   logic [DATA_WIDTH:0] sat_re, sat_im;

   function automatic logic [DATA_WIDTH:0] saturate(input logic neg,
                                                     input logic [PROD_W-1:0] mag);
      logic [DATA_WIDTH:0] r;
      if (!neg) begin
         if (mag > MAX_POS) r = {1'b1, MAX_POS[DATA_WIDTH-1:0]};
         else               r = {1'b0, mag[DATA_WIDTH-1:0]};
      end else begin
         if (mag > MAX_NEG) r = {1'b1, MAX_NEG[DATA_WIDTH-1:0]};
         else               r = {1'b0, DATA_WIDTH'(-mag[DATA_WIDTH-1:0])};
      end
      return r;
   endfunction

   always_comb begin
      if (in_pipe.kind == OP_DIV) begin
         fin_re = in_pipe.big_re ? '1 : PROD_W'(in_pipe.re.quo);
         fin_im = in_pipe.big_im ? '1 : PROD_W'(in_pipe.im.quo);
      end else begin
         fin_re = in_pipe.mag_re;
         fin_im = in_pipe.mag_im;
      end
      sat_re = saturate(in_pipe.neg_re, fin_re);
      sat_im = saturate(in_pipe.neg_im, fin_im);
      if (in_pipe.div_zero) begin
         rsp_in = '0;
         rsp_in.div_zero = 1'b1;
      end else begin
         rsp_in.res_re   = sat_re[DATA_WIDTH-1:0];
         rsp_in.res_im   = sat_im[DATA_WIDTH-1:0];
         rsp_in.overflow = sat_re[DATA_WIDTH] | sat_im[DATA_WIDTH];
         rsp_in.div_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ===== rtl/complex_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// Every operation passes the four front register stages, the divider steps
// and the output register before rsp_valid rises with its response.
// Throughput: one request per cycle; busy is never raised.
// The divider is 33 registered restoring steps, one quotient bit per stage.
// Reset clears all valid bits; no results are produced for in-flight requests.
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic     v_chain [DIV_STEPS+1];
   pipe_type p_chain [DIV_STEPS+1];

   assign busy = 1'b0;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .out_valid (v_chain[0]),
      .out_pipe  (p_chain[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      cau_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_chain[i]),
         .in_pipe   (p_chain[i]),
         .out_valid (v_chain[i+1]),
         .out_pipe  (p_chain[i+1])
      );
   end

   cau_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_chain[DIV_STEPS]),
      .in_pipe   (p_chain[DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request did not complete in fixed latency");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.overflow && rsp_data.div_zero))
      else $error("overflow and divide-by-zero both set");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_zero) |-> (rsp_data.res_re == '0 && rsp_data.res_im == '0))
      else $error("divide-by-zero result not zero");

endmodule
